// ===== hw/rtl/cals_pkg.sv =====
// Package for the conflict-aware list scheduler: widths, request/result
// structs and the minimum-search tree shared by the scheduling core.
// No dependencies.
package cals_pkg;

  localparam int Machines  = 8;
  localparam int Jobs      = 64;
  localparam int MachIdxW  = (Machines > 1) ? $clog2(Machines) : 1;
  localparam int MachCntW  = $clog2(Machines + 1);
  localparam int TreeN     = 2 ** MachIdxW;
  localparam int JobIdW    = 6;
  localparam int JobLenW   = 16;
  localparam int RowW      = 64;
  localparam int TimeW     = 32;
  localparam int MachineW  = 3;
  localparam int CfgW      = 4;

  localparam int InDataW   = JobIdW + JobLenW + RowW;
  localparam int InTdataW  = ((InDataW + 7) / 8) * 8;
  localparam int OutDataW  = MachineW + 4 * TimeW;
  localparam int OutTdataW = ((OutDataW + 7) / 8) * 8;

  localparam logic [TimeW-1:0]    TimeMax      = '1;
  localparam logic [CfgW-1:0]     CfgReset     = CfgW'(8);

  typedef struct packed {
    logic               first;
    logic [JobIdW-1:0]  id;
    logic [JobLenW-1:0] len;
    logic [RowW-1:0]    row;
  } job_t;

  typedef struct packed {
    logic [MachineW-1:0] machine;
    logic [TimeW-1:0]    start_time;
    logic [TimeW-1:0]    end_time;
    logic [TimeW-1:0]    makespan;
    logic [TimeW-1:0]    earliest_free;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [MachIdxW-1:0] idx;
    logic [TimeW-1:0]    val;
  } cand_t;

  // Pairwise tree; the lower index wins ties.
  function automatic cand_t min_tree(input logic [Machines-1:0] vld,
                                     input logic [Machines-1:0][TimeW-1:0] vals);
    cand_t lvl [TreeN];
    for (int i = 0; i < TreeN; i++) begin
      lvl[i].idx = MachIdxW'(i);
      if (i < Machines) begin
        lvl[i].valid = vld[i];
        lvl[i].val   = vals[i];
      end else begin
        lvl[i].valid = 1'b0;
        lvl[i].val   = TimeMax;
      end
    end
    for (int s = 1; s < TreeN; s = s * 2) begin
      for (int i = 0; i + s < TreeN; i = i + 2 * s) begin
        if (lvl[i+s].valid && (!lvl[i].valid || (lvl[i+s].val < lvl[i].val))) begin
          lvl[i] = lvl[i+s];
        end
      end
    end
    return lvl[0];
  endfunction

endpackage

// ===== hw/rtl/cals_core.sv =====
// Scheduling core: machine state, machine choice, conflict wait, timing
// and result formation for the job held in the input register.
// Depends on cals_pkg.
module cals_core
  import cals_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  job_t            job_i,
  input  logic [CfgW-1:0] cfg_i,
  output result_t         res_o
);

  logic [Machines-1:0][TimeW-1:0]  finish_q, finish_d, eff_finish, inv_finish;
  logic [Machines-1:0][JobIdW-1:0] last_q, last_d, eff_last;
  logic [MachCntW-1:0]             filled_q, filled_d, eff_filled;
  logic [TimeW-1:0]                mkspan_q, mkspan_d, eff_mkspan;

  logic [MachCntW-1:0] act, used_old, used_new;
  logic                fill;
  logic [Machines-1:0] act_vld, hit, new_vld;
  cand_t               pick, cmax_inv, low_new;
  logic [MachIdxW-1:0] chosen;
  logic [TimeW-1:0]    base, cmax, start, end_t;
  logic [TimeW:0]      sum;

  always_comb begin
    if (cfg_i == '0) begin
      act = MachCntW'(1);
    end else if (32'(cfg_i) > Machines) begin
      act = MachCntW'(Machines);
    end else begin
      act = MachCntW'(cfg_i);
    end
  end

  always_comb begin
    if (job_i.first) begin
      eff_finish = '0;
      eff_last   = '0;
      eff_filled = '0;
      eff_mkspan = '0;
    end else begin
      eff_finish = finish_q;
      eff_last   = last_q;
      eff_filled = filled_q;
      eff_mkspan = mkspan_q;
    end
  end

  assign fill     = eff_filled < act;
  assign used_old = fill ? eff_filled : act;

  always_comb begin
    for (int m = 0; m < Machines; m++) begin
      act_vld[m]    = MachCntW'(m) < act;
      hit[m]        = (MachCntW'(m) < used_old) && (32'(eff_last[m]) < Jobs)
                      && job_i.row[eff_last[m]];
      inv_finish[m] = ~eff_finish[m];
    end
  end

  assign pick     = min_tree(act_vld, eff_finish);
  assign cmax_inv = min_tree(hit, inv_finish);
  assign cmax     = cmax_inv.valid ? ~cmax_inv.val : '0;

  assign chosen = fill ? MachIdxW'(eff_filled) : pick.idx;
  assign base   = fill ? '0 : pick.val;
  assign start  = (cmax > base) ? cmax : base;
  assign sum    = {1'b0, start} + (TimeW + 1)'(job_i.len);
  assign end_t  = sum[TimeW] ? TimeMax : sum[TimeW-1:0];

  always_comb begin
    finish_d = eff_finish;
    last_d   = eff_last;
    finish_d[chosen] = end_t;
    last_d[chosen]   = job_i.id;
  end

  assign filled_d = eff_filled + MachCntW'(fill);
  assign used_new = (filled_d < act) ? filled_d : act;
  assign mkspan_d = (end_t > eff_mkspan) ? end_t : eff_mkspan;

  always_comb begin
    for (int m = 0; m < Machines; m++) begin
      new_vld[m] = MachCntW'(m) < used_new;
    end
  end

  assign low_new = min_tree(new_vld, finish_d);

  assign res_o.machine       = MachineW'(chosen);
  assign res_o.start_time    = start;
  assign res_o.end_time      = end_t;
  assign res_o.makespan      = mkspan_d;
  assign res_o.earliest_free = low_new.valid ? low_new.val : TimeMax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finish_q <= '0;
      last_q   <= '0;
      filled_q <= '0;
      mkspan_q <= '0;
    end else if (fire_i) begin
      finish_q <= finish_d;
      last_q   <= last_d;
      filled_q <= filled_d;
      mkspan_q <= mkspan_d;
    end
  end

`ifndef SYNTH
  a_filled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(filled_q) <= Machines)
    else $error("fill count beyond machine count");
  a_chosen_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> (MachCntW'(chosen) < act))
    else $error("job placed on inactive machine");
  a_end_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> (end_t >= start))
    else $error("end time before start time");
  a_mkspan_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fire_i) && !$past(job_i.first) |-> (mkspan_q >= $past(mkspan_q)))
    else $error("makespan decreased without a clear");
`endif

endmodule

// ===== hw/rtl/conflict_aware_list_scheduler.sv =====
// Top level of the conflict-aware list scheduler: input register, output
// register, stream handshakes and the machine-count register.
// Depends on cals_pkg and cals_core.
//
// Usage: jobs enter on the s_axis channel, one request per job; tuser
// carries the first-job flag, which clears all machine state before the
// job is placed. Each job yields exactly one result on m_axis: machine,
// start and end time, running makespan and earliest free time.
// The cfg channel writes the active machine count (0 acts as 1, values
// above the machine count act as the machine count); write it only while
// no job is in flight. cfg_ready_o is always high.
// A job held in the input register moves its result into the output register
// when it advances. Throughput: one job per cycle while the output is not
// stalled; the core between the two registers reads and updates machine state.
// Stalls: if m_axis_tready is low, the output register holds its result
// and one more job may wait in the input register; s_axis_tready drops
// only when both are full and the output is not taken.
// Reset: all machine state, the fill count and the makespan clear, the
// machine count returns to 8 and both registers empty.
module conflict_aware_list_scheduler
  import cals_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [5:0] job_id, [21:6] job_length, [85:22] conflict_row, rest zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // [0] first_job
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [2:0] machine, [34:3] start_time, [66:35] end_time,
  // [98:67] makespan, [130:99] earliest_free, rest zero
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgW-1:0]      cfg_data_i
);

  logic            in_valid_q, out_valid_q, advance;
  job_t            job_q;
  result_t         res, res_q;
  logic [CfgW-1:0] cfg_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= CfgReset;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      job_q.first <= s_axis_tuser;
      job_q.id    <= s_axis_tdata[JobIdW-1:0];
      job_q.len   <= s_axis_tdata[JobIdW +: JobLenW];
      job_q.row   <= s_axis_tdata[JobIdW+JobLenW +: RowW];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  cals_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .job_i  (job_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({res_q.earliest_free, res_q.makespan, res_q.end_time,
                                     res_q.start_time, res_q.machine});

endmodule
